/* sv/stp_pkg.sv */
// Package: widths, reset values and register indexes for the structure tensor precision block
package stp_pkg;

   localparam int AreaWidth     = 27;
   localparam int WeightWidth   = 17;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 27;

   localparam logic [AreaWidth-1:0]   AreaReset   = 27'd3211264;
   localparam logic [WeightWidth-1:0] WeightReset = 17'd62862;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_AREA_WEIGHT      = 1'b0,
      CSR_PRECISION_WEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [30:0] tensor_xx;
      logic signed [31:0] tensor_xy;
      logic [30:0] tensor_yy;
      logic signed [31:0] error_zero_deg;
      logic signed [31:0] error_sixty_deg;
      logic signed [31:0] error_onetwenty_deg;
   } req_payload_type;

   typedef struct packed {
      logic [30:0] smallest_eigen;
      logic signed [31:0] precision_value;
      logic zero_divisor;
   } rsp_payload_type;

endpackage

/* sv/stp_stream_if.sv */
// Interface: valid/ready stream channel carrying one payload type
interface stp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/structure_tensor_precision_top.sv */
// Top level: pipelined smallest eigenvalue and precision per pixel
//
//   channel | dir | handshake        | payload
//   req     | in  | req.valid/ready  | tensor terms and three model errors
//   rsp     | out | rsp.valid/ready  | smallest_eigen, precision_value, zero_divisor
//   csr     | in  | csr_write_enable | csr_index, csr_data
//
// One item per cycle sustained while the output is not stalled. Each item passes through
// the two 32-step square-root pipelines and the 64-step restoring divider pipeline.
// Reset clears all valid bits and loads the register reset values.
// A stall freezes the whole pipeline; req.ready is low only while the output holds.
module structure_tensor_precision_top
   import stp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   stp_stream_if.sink               req,
   stp_stream_if.source             rsp,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   localparam int SqSteps  = 32;
   localparam int DivSteps = 64;

   logic [AreaWidth-1:0]   area_ff;
   logic [WeightWidth-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff   <= AreaReset;
         weight_ff <= WeightReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_AREA_WEIGHT:      area_ff   <= csr_data[AreaWidth-1:0];
            CSR_PRECISION_WEIGHT: weight_ff <= csr_data[WeightWidth-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances together
   logic advance;
   assign advance  = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // ---------------- stage A: operand products, loaded into square-root stage 0
   logic        sq_vld_ff [SqSteps+1];
   logic [63:0] e_rem_ff  [SqSteps+1];
   logic [31:0] e_root_ff [SqSteps+1];
   logic [63:0] o_rem_ff  [SqSteps+1];
   logic [31:0] o_root_ff [SqSteps+1];
   logic signed [32:0] sq_tr_ff  [SqSteps+1];   // xx+yy
   logic signed [33:0] sq_sum_ff [SqSteps+1];   // a+b+c
   logic [65:0]        e_trial   [SqSteps];
   logic [65:0]        o_trial   [SqSteps];
   logic signed [32:0] d_s, ux, uy;
   logic [65:0]        d2;
   logic [63:0]        xy2;
   logic signed [66:0] rad_full;

   always_comb begin
      d_s = $signed({2'b0, req.payload.tensor_xx}) - $signed({2'b0, req.payload.tensor_yy});
      d2  = 66'($signed(d_s) * $signed(d_s));
      xy2 = 64'($signed(req.payload.tensor_xy) * $signed(req.payload.tensor_xy));
      ux  = 33'(req.payload.error_zero_deg) - 33'(req.payload.error_sixty_deg);
      uy  = 33'(req.payload.error_sixty_deg) - 33'(req.payload.error_onetwenty_deg);
      rad_full = 67'(ux * ux) + 67'(ux * uy) + 67'(uy * uy);
   end

   // ---------------- square roots: one result bit per stage, both in lockstep
   always_comb begin
      for (int k = 0; k < SqSteps; k++) begin
         e_trial[k] = (66'(e_root_ff[k]) << (2 * (SqSteps - 1 - k) + 2))
                      | (66'd1 << (2 * (SqSteps - 1 - k)));
         o_trial[k] = (66'(o_root_ff[k]) << (2 * (SqSteps - 1 - k) + 2))
                      | (66'd1 << (2 * (SqSteps - 1 - k)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SqSteps; k++) sq_vld_ff[k] <= 1'b0;
      end else if (advance) begin
         sq_vld_ff[0] <= req.valid;
         for (int k = 0; k < SqSteps; k++) sq_vld_ff[k+1] <= sq_vld_ff[k];
      end
      if (advance) begin
         sq_tr_ff[0]  <= $signed({2'b0, req.payload.tensor_xx})
                         + $signed({2'b0, req.payload.tensor_yy});
         sq_sum_ff[0] <= 34'(req.payload.error_zero_deg) + 34'(req.payload.error_sixty_deg)
                         + 34'(req.payload.error_onetwenty_deg);
         e_rem_ff[0]  <= 64'(d2 >> 2) + xy2;
         e_root_ff[0] <= '0;
         o_rem_ff[0]  <= rad_full[63:0];
         o_root_ff[0] <= '0;
         for (int k = 0; k < SqSteps; k++) begin
            sq_tr_ff[k+1]  <= sq_tr_ff[k];
            sq_sum_ff[k+1] <= sq_sum_ff[k];
            if ({2'b0, e_rem_ff[k]} >= e_trial[k]) begin
               e_rem_ff[k+1]  <= 64'({2'b0, e_rem_ff[k]} - e_trial[k]);
               e_root_ff[k+1] <= {e_root_ff[k][30:0], 1'b1};
            end else begin
               e_rem_ff[k+1]  <= e_rem_ff[k];
               e_root_ff[k+1] <= {e_root_ff[k][30:0], 1'b0};
            end
            if ({2'b0, o_rem_ff[k]} >= o_trial[k]) begin
               o_rem_ff[k+1]  <= 64'({2'b0, o_rem_ff[k]} - o_trial[k]);
               o_root_ff[k+1] <= {o_root_ff[k][30:0], 1'b1};
            end else begin
               o_rem_ff[k+1]  <= o_rem_ff[k];
               o_root_ff[k+1] <= {o_root_ff[k][30:0], 1'b0};
            end
         end
      end
   end

   // ---------------- stage B: lambda and tripled omega
   logic               b_vld_ff;
   logic signed [34:0] b_lam_ff;
   logic signed [35:0] b_w3_ff;

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= sq_vld_ff[SqSteps];
      if (advance) begin
         b_lam_ff <= 35'(sq_tr_ff[SqSteps]) - $signed({2'b0, e_root_ff[SqSteps], 1'b0});
         b_w3_ff  <= 36'(sq_sum_ff[SqSteps]) - $signed({3'b0, o_root_ff[SqSteps], 1'b0});
      end
   end

   // ---------------- stage C: scale by M, clamp, saturate
   logic               c_vld_ff;
   logic [30:0]        c_eig_ff;
   logic signed [35:0] c_w3_ff;
   logic [60:0]        lam_prod;
   logic [43:0]        lam_shift;

   always_comb begin
      lam_prod  = 61'(b_lam_ff[33:0]) * 61'(area_ff);
      lam_shift = lam_prod[60:17];
   end

   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= b_vld_ff;
      if (advance) begin
         c_w3_ff <= b_w3_ff;
         if (b_lam_ff <= 0) c_eig_ff <= '0;
         else if (|lam_shift[43:31]) c_eig_ff <= '1;
         else c_eig_ff <= lam_shift[30:0];
      end
   end

   // ---------------- stage D: numerator and divisor magnitude, loaded into divider stage 0
   // restoring divider: one quotient bit per stage
   logic        dv_vld_ff  [DivSteps+1];
   logic [63:0] dv_quo_ff  [DivSteps+1];   // dividend shifts out, quotient shifts in
   logic [36:0] dv_rem_ff  [DivSteps+1];
   logic [35:0] dv_den_ff  [DivSteps+1];
   logic        dv_neg_ff  [DivSteps+1];
   logic        dv_zero_ff [DivSteps+1];
   logic [30:0] dv_eig_ff  [DivSteps+1];
   logic [37:0] dv_shift   [DivSteps];
   logic [49:0] num_prod;

   always_comb num_prod = 50'(3 * 19'(weight_ff)) * 50'(c_eig_ff);

   always_comb begin
      for (int k = 0; k < DivSteps; k++) dv_shift[k] = {dv_rem_ff[k], dv_quo_ff[k][63]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivSteps; k++) dv_vld_ff[k] <= 1'b0;
      end else if (advance) begin
         dv_vld_ff[0] <= c_vld_ff;
         for (int k = 0; k < DivSteps; k++) dv_vld_ff[k+1] <= dv_vld_ff[k];
      end
      if (advance) begin
         dv_eig_ff[0]  <= c_eig_ff;
         dv_quo_ff[0]  <= 64'(num_prod);
         dv_rem_ff[0]  <= '0;
         dv_neg_ff[0]  <= c_w3_ff < 0;
         dv_den_ff[0]  <= c_w3_ff < 0 ? 36'(-c_w3_ff) : 36'(c_w3_ff);
         dv_zero_ff[0] <= c_w3_ff == 0;
         for (int k = 0; k < DivSteps; k++) begin
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            dv_eig_ff[k+1]  <= dv_eig_ff[k];
            if (dv_shift[k] >= {2'b0, dv_den_ff[k]}) begin
               dv_rem_ff[k+1] <= 37'(dv_shift[k] - {2'b0, dv_den_ff[k]});
               dv_quo_ff[k+1] <= {dv_quo_ff[k][62:0], 1'b1};
            end else begin
               dv_rem_ff[k+1] <= dv_shift[k][36:0];
               dv_quo_ff[k+1] <= {dv_quo_ff[k][62:0], 1'b0};
            end
         end
      end
   end

   // ---------------- output stage: sign, saturate
   logic [63:0]     q_fin;
   rsp_payload_type out_in;
   logic            out_vld_ff;
   rsp_payload_type out_ff;

   always_comb begin
      q_fin = dv_quo_ff[DivSteps];
      out_in.smallest_eigen = dv_eig_ff[DivSteps];
      out_in.zero_divisor   = dv_zero_ff[DivSteps];
      if (dv_zero_ff[DivSteps]) out_in.precision_value = '0;
      else if (dv_neg_ff[DivSteps]) begin
         if (q_fin > 64'h8000_0000) out_in.precision_value = 32'sh8000_0000;
         else out_in.precision_value = 32'(64'd0 - q_fin);
      end else begin
         if (q_fin > 64'h7FFF_FFFF) out_in.precision_value = 32'sh7FFF_FFFF;
         else out_in.precision_value = q_fin[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= dv_vld_ff[DivSteps];
      if (advance) out_ff <= out_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

   a_zero_prec: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.zero_divisor |-> rsp.payload.precision_value == 0)
      else $error("precision nonzero with zero divisor");
   a_zero_eig: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.smallest_eigen == 0 |-> rsp.payload.precision_value == 0)
      else $error("precision nonzero with zero eigenvalue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(out_ff) && out_vld_ff)
      else $error("output changed during stall");

endmodule
